### design/kcc_pkg.sv
// Shared constants and controller/datapath interface types for the colour clustering block.
`default_nettype none
package kcc_pkg;

  localparam int unsigned MaxPoints   = 4096;
  localparam int unsigned MaxClusters = 16;
  localparam int unsigned StopShift   = 10;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned CenW        = 16;
  localparam int unsigned OutWeightW  = 20;
  localparam int unsigned OutIndexW   = 4;
  localparam int unsigned DivSteps    = 16;

  localparam logic [4:0] ClusterCountRst = 5'd4;
  localparam logic [7:0] IterLimitRst    = 8'd64;

  localparam logic [1:0] CompRed   = 2'd0;
  localparam logic [1:0] CompGreen = 2'd1;
  localparam logic [1:0] CompBlue  = 2'd2;

  typedef enum logic [0:0] {
    CFG_CLUSTER_COUNT = 1'b0,
    CFG_ITER_LIMIT    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       load_wr;
    logic       acc_rd;
    logic       use_init;
    logic       clr_sums;
    logic       div_load;
    logic       div_step;
    logic       div_save;
    logic       cen_zero;
    logic       pt_latch;
    logic       dist_issue;
    logic       wb;
    logic       out_load;
    logic       out_last;
    logic       ovf;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic w_nz;
    logic changed;
  } st_t;

endpackage
`default_nettype wire

### design/kmeans_color_clustering.sv
// Weighted k-means colour clustering: top level.
//
// Input channel (in_valid_i / in_stall_o): one weighted RGB point per word,
// taken one per cycle while the set is loading. last_point_i closes the set.
// Points beyond the store depth are dropped and flagged in every result.
// After the closing word the input stalls while the clustering runs:
//   accumulate pass: one point store read per cycle,
//   centroid pass:   16-step divider, three colours per cluster,
//   reassign pass:   one cluster distance per cycle,
// repeated per Lloyd iteration over all points and clusters.
// Output channel (out_valid_o / out_stall_i): K result words in cluster
// order, at most one per cycle, last_result_o on the final one. A result
// waits in the output register while stalled; the next set may begin
// loading while the final result still waits.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i; write
// only while the block is idle.
// Reset (rst_ni low, asynchronous) empties the set and restores defaults.
`default_nettype none
module kmeans_color_clustering #(
  parameter int unsigned MAX_POINTS   = kcc_pkg::MaxPoints,
  parameter int unsigned MAX_CLUSTERS = kcc_pkg::MaxClusters,
  parameter int unsigned STOP_SHIFT   = kcc_pkg::StopShift
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  weight_i,
  input  logic        last_point_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  cluster_index_o,
  output logic [15:0] center_red_o,
  output logic [15:0] center_green_o,
  output logic [15:0] center_blue_o,
  output logic [19:0] member_weight_o,
  output logic        points_dropped_o,
  output logic        last_result_o
);
  import kcc_pkg::*;

  localparam int unsigned PA_W = $clog2(MAX_POINTS);
  localparam int unsigned CI_W = $clog2(MAX_CLUSTERS);

  cmd_t            cmd;
  st_t             st;
  logic [PA_W-1:0] addr;
  logic [CI_W-1:0] ci;
  logic [CI_W-1:0] grp;

  kcc_ctrl #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .STOP_SHIFT   (STOP_SHIFT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_last_i   (last_point_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .addr_o      (addr),
    .ci_o        (ci),
    .grp_o       (grp),
    .st_i        (st)
  );

  kcc_dpath #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .addr_i           (addr),
    .ci_i             (ci),
    .grp_i            (grp),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .weight_i         (weight_i),
    .st_o             (st),
    .cluster_index_o  (cluster_index_o),
    .center_red_o     (center_red_o),
    .center_green_o   (center_green_o),
    .center_blue_o    (center_blue_o),
    .member_weight_o  (member_weight_o),
    .points_dropped_o (points_dropped_o),
    .last_result_o    (last_result_o)
  );

endmodule
`default_nettype wire

### design/kcc_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module kcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### design/kcc_ctrl.sv
// Sequencer for loading, Lloyd iterations and result emission, plus configuration registers.
`default_nettype none
module kcc_ctrl #(
  parameter int unsigned MAX_POINTS   = 4096,
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned STOP_SHIFT   = 10,
  localparam int unsigned PA_W  = $clog2(MAX_POINTS),
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1),
  localparam int unsigned CI_W  = $clog2(MAX_CLUSTERS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_stall_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output kcc_pkg::cmd_t    cmd_o,
  output logic [PA_W-1:0]  addr_o,
  output logic [CI_W-1:0]  ci_o,
  output logic [CI_W-1:0]  grp_o,
  input  kcc_pkg::st_t     st_i
);
  import kcc_pkg::*;

  localparam int unsigned K_W = $clog2(MAX_CLUSTERS + 1);

  typedef enum logic [14:0] {
    S_LOAD     = 15'b000000000000001,
    S_CLR      = 15'b000000000000010,
    S_ACC      = 15'b000000000000100,
    S_ACC_W    = 15'b000000000001000,
    S_DIV_SEL  = 15'b000000000010000,
    S_DIV_LOAD = 15'b000000000100000,
    S_DIV_RUN  = 15'b000000001000000,
    S_DIV_SAVE = 15'b000000010000000,
    S_RD       = 15'b000000100000000,
    S_LATCH    = 15'b000001000000000,
    S_SCAN     = 15'b000010000000000,
    S_DRAIN    = 15'b000100000000000,
    S_WB       = 15'b001000000000000,
    S_ITER_END = 15'b010000000000000,
    S_EMIT     = 15'b100000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic             ovf_q, ovf_d;
  logic [K_W-1:0]   k_q, k_d;
  logic [7:0]       limit_q, limit_d;
  logic [7:0]       iter_q, iter_d;
  logic             first_q, first_d;
  logic [PA_W-1:0]  j_q, j_d;
  logic [CI_W-1:0]  jm_q, jm_d;
  logic [CI_W-1:0]  i_q, i_d;
  logic [1:0]       comp_q, comp_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0] chg_q, chg_d;
  logic             out_valid_q, out_valid_d;
  logic [4:0]       cc_q;
  logic [7:0]       il_q;

  logic             in_accept;
  logic             last_pt;
  logic             last_cl;
  logic [CI_W-1:0]  jm_next;
  logic             out_free;
  logic [K_W-1:0]   k_clamp;

  assign in_stall_o  = (state_q != S_LOAD);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_pt     = (j_q == PA_W'(total_q - 1'b1));
  assign last_cl     = (i_q == CI_W'(k_q - 1'b1));
  assign jm_next     = (jm_q == CI_W'(k_q - 1'b1)) ? '0 : jm_q + 1'b1;

  always_comb begin
    if (cc_q == 5'd0) begin
      k_clamp = K_W'(1);
    end else if (32'(cc_q) > MAX_CLUSTERS) begin
      k_clamp = K_W'(MAX_CLUSTERS);
    end else begin
      k_clamp = K_W'(cc_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    k_d         = k_q;
    limit_d     = limit_q;
    iter_d      = iter_q;
    first_d     = first_q;
    j_d         = j_q;
    jm_d        = jm_q;
    i_d         = i_q;
    comp_d      = comp_q;
    cnt_d       = cnt_q;
    chg_d       = chg_q;
    cmd_o          = '0;
    cmd_o.ovf      = ovf_q;
    cmd_o.use_init = first_q;
    cmd_o.comp     = comp_q;
    addr_o      = j_q;
    ci_o        = i_q;
    grp_o       = jm_q;

    unique case (state_q)
      S_LOAD: begin
        addr_o = total_q[PA_W-1:0];
        if (in_accept) begin
          if (total_q < CNT_W'(MAX_POINTS)) begin
            cmd_o.load_wr = 1'b1;
            total_d       = total_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            k_d     = k_clamp;
            limit_d = (il_q == 8'd0) ? 8'd1 : il_q;
            iter_d  = '0;
            first_d = 1'b1;
            state_d = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd_o.clr_sums = 1'b1;
        j_d     = '0;
        jm_d    = '0;
        chg_d   = '0;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_rd = 1'b1;
        j_d  = j_q + 1'b1;
        jm_d = jm_next;
        if (last_pt) begin
          state_d = S_ACC_W;
        end
      end
      S_ACC_W: begin
        i_d     = '0;
        state_d = S_DIV_SEL;
      end
      S_DIV_SEL: begin
        if (st_i.w_nz) begin
          comp_d  = CompRed;
          state_d = S_DIV_LOAD;
        end else begin
          cmd_o.cen_zero = 1'b1;
          if (last_cl) begin
            j_d     = '0;
            jm_d    = '0;
            state_d = S_RD;
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      S_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d   = '0;
        state_d = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'(DivSteps - 1)) begin
          state_d = S_DIV_SAVE;
        end
      end
      S_DIV_SAVE: begin
        cmd_o.div_save = 1'b1;
        if (comp_q == CompBlue) begin
          if (last_cl) begin
            j_d     = '0;
            jm_d    = '0;
            state_d = S_RD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_DIV_SEL;
          end
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = S_DIV_LOAD;
        end
      end
      S_RD: begin
        state_d = S_LATCH;
      end
      S_LATCH: begin
        cmd_o.pt_latch = 1'b1;
        i_d     = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.dist_issue = 1'b1;
        if (last_cl) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_DRAIN: begin
        // wait for the distance pipe to settle the best match
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd1) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        if (st_i.changed) begin
          chg_d = chg_q + 1'b1;
        end
        j_d  = j_q + 1'b1;
        jm_d = jm_next;
        state_d = last_pt ? S_ITER_END : S_RD;
      end
      S_ITER_END: begin
        iter_d  = iter_q + 1'b1;
        first_d = 1'b0;
        if ((chg_q > (total_q >> STOP_SHIFT)) &&
            (({1'b0, iter_q} + 9'd1) < {1'b0, limit_q})) begin
          state_d = S_CLR;
        end else begin
          i_d     = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = last_cl;
          if (last_cl) begin
            total_d = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      k_q         <= K_W'(1);
      limit_q     <= 8'd1;
      iter_q      <= '0;
      first_q     <= 1'b0;
      j_q         <= '0;
      jm_q        <= '0;
      i_q         <= '0;
      comp_q      <= CompRed;
      cnt_q       <= '0;
      chg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      k_q         <= k_d;
      limit_q     <= limit_d;
      iter_q      <= iter_d;
      first_q     <= first_d;
      j_q         <= j_d;
      jm_q        <= jm_d;
      i_q         <= i_d;
      comp_q      <= comp_d;
      cnt_q       <= cnt_d;
      chg_q       <= chg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= ClusterCountRst;
      il_q <= IterLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CLUSTER_COUNT: cc_q <= cfg_data_i[4:0];
        CFG_ITER_LIMIT:    il_q <= cfg_data_i;
        default:           il_q <= il_q;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/kcc_dpath.sv
// Point store, weighted sums, serial divider, distance pipe and result register.
`default_nettype none
module kcc_dpath #(
  parameter int unsigned MAX_POINTS   = 4096,
  parameter int unsigned MAX_CLUSTERS = 16,
  localparam int unsigned PA_W = $clog2(MAX_POINTS),
  localparam int unsigned CI_W = $clog2(MAX_CLUSTERS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kcc_pkg::cmd_t    cmd_i,
  input  logic [PA_W-1:0]  addr_i,
  input  logic [CI_W-1:0]  ci_i,
  input  logic [CI_W-1:0]  grp_i,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  input  logic [7:0]       weight_i,
  output kcc_pkg::st_t     st_o,
  output logic [3:0]       cluster_index_o,
  output logic [15:0]      center_red_o,
  output logic [15:0]      center_green_o,
  output logic [15:0]      center_blue_o,
  output logic [19:0]      member_weight_o,
  output logic             points_dropped_o,
  output logic             last_result_o
);
  import kcc_pkg::*;

  localparam int unsigned WGT_W = $clog2(MAX_POINTS * 255 + 1);
  localparam int unsigned SUM_W = $clog2(64'(MAX_POINTS) * 64'd65025 + 64'd1);
  localparam int unsigned PT_W  = 4 * ChanW + CI_W;
  localparam int unsigned DIST_W = 2 * CenW + 2;

  // point store
  logic             ram_we;
  logic [PT_W-1:0]  ram_wdata;
  logic [PT_W-1:0]  ram_rdata;
  logic [7:0]       rd_r, rd_g, rd_b, rd_w;
  logic [CI_W-1:0]  rd_grp;

  // per-point working copy
  logic [7:0]       pr_q, pg_q, pb_q, pw_q;
  logic [CI_W-1:0]  pgrp_q, best_q;
  logic [DIST_W-1:0] best_d_q;
  logic             have_q;

  assign rd_r   = ram_rdata[PT_W-1 -: 8];
  assign rd_g   = ram_rdata[PT_W-9 -: 8];
  assign rd_b   = ram_rdata[PT_W-17 -: 8];
  assign rd_w   = ram_rdata[PT_W-25 -: 8];
  assign rd_grp = ram_rdata[CI_W-1:0];

  assign ram_we    = cmd_i.load_wr || cmd_i.wb;
  assign ram_wdata = cmd_i.load_wr ? {red_i, green_i, blue_i, weight_i, CI_W'(0)}
                                   : {pr_q, pg_q, pb_q, pw_q, best_q};

  kcc_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_i),
    .wdata_i (ram_wdata),
    .raddr_i (addr_i),
    .rdata_o (ram_rdata)
  );

  // accumulation
  logic             acc_v_q;
  logic             acc_init_q;
  logic [CI_W-1:0]  acc_grp_q;
  logic [CI_W-1:0]  acc_g;
  logic [SUM_W-1:0] sum_r_q [MAX_CLUSTERS];
  logic [SUM_W-1:0] sum_g_q [MAX_CLUSTERS];
  logic [SUM_W-1:0] sum_b_q [MAX_CLUSTERS];
  logic [WGT_W-1:0] wgt_q   [MAX_CLUSTERS];

  assign acc_g = acc_init_q ? acc_grp_q : rd_grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_v_q <= 1'b0;
    end else begin
      acc_v_q <= cmd_i.acc_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_init_q <= cmd_i.use_init;
    acc_grp_q  <= grp_i;
    if (cmd_i.clr_sums) begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        sum_r_q[c] <= '0;
        sum_g_q[c] <= '0;
        sum_b_q[c] <= '0;
        wgt_q[c]   <= '0;
      end
    end else if (acc_v_q) begin
      sum_r_q[acc_g] <= sum_r_q[acc_g] + SUM_W'(16'(rd_r) * 16'(rd_w));
      sum_g_q[acc_g] <= sum_g_q[acc_g] + SUM_W'(16'(rd_g) * 16'(rd_w));
      sum_b_q[acc_g] <= sum_b_q[acc_g] + SUM_W'(16'(rd_b) * 16'(rd_w));
      wgt_q[acc_g]   <= wgt_q[acc_g] + WGT_W'(rd_w);
    end
  end

  assign st_o.w_nz    = (wgt_q[ci_i] != '0);
  assign st_o.changed = (best_q != pgrp_q);

  // restoring divider, one quotient bit a cycle
  logic [SUM_W-1:0] div_num;
  logic [WGT_W-1:0] div_rem_q, div_den_q;
  logic [15:0]      div_lo_q, div_quo_q;
  logic [WGT_W:0]   div_t;
  logic             div_ge;

  always_comb begin
    case (cmd_i.comp)
      CompRed:   div_num = sum_r_q[ci_i];
      CompGreen: div_num = sum_g_q[ci_i];
      default:   div_num = sum_b_q[ci_i];
    endcase
  end

  assign div_t  = {div_rem_q, div_lo_q[15]};
  assign div_ge = (div_t >= {1'b0, div_den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      div_rem_q <= WGT_W'(div_num >> 8);
      div_lo_q  <= {div_num[7:0], 8'h00};
      div_den_q <= wgt_q[ci_i];
      div_quo_q <= '0;
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_ge ? WGT_W'(div_t - {1'b0, div_den_q}) : WGT_W'(div_t);
      div_lo_q  <= {div_lo_q[14:0], 1'b0};
      div_quo_q <= {div_quo_q[14:0], div_ge};
    end
  end

  // centroid store
  logic [CenW-1:0] cen_r_q [MAX_CLUSTERS];
  logic [CenW-1:0] cen_g_q [MAX_CLUSTERS];
  logic [CenW-1:0] cen_b_q [MAX_CLUSTERS];
  logic            cen_v_q [MAX_CLUSTERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        cen_v_q[c] <= 1'b0;
      end
    end else if (cmd_i.cen_zero) begin
      cen_v_q[ci_i] <= 1'b0;
    end else if (cmd_i.div_save && (cmd_i.comp == CompBlue)) begin
      cen_v_q[ci_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cen_zero) begin
      cen_r_q[ci_i] <= '0;
      cen_g_q[ci_i] <= '0;
      cen_b_q[ci_i] <= '0;
    end else if (cmd_i.div_save) begin
      case (cmd_i.comp)
        CompRed:   cen_r_q[ci_i] <= div_quo_q;
        CompGreen: cen_g_q[ci_i] <= div_quo_q;
        default:   cen_b_q[ci_i] <= div_quo_q;
      endcase
    end
  end

  // distance pipe: difference, square, sum and compare
  logic [CenW-1:0]   a_r, a_g, a_b;
  logic [CenW-1:0]   c_r, c_g, c_b;
  logic              s1_v_q, s2_v_q;
  logic              s1_cv_q, s2_cv_q;
  logic [CI_W-1:0]   s1_idx_q, s2_idx_q;
  logic [CenW-1:0]   s1_dr_q, s1_dg_q, s1_db_q;
  logic [2*CenW-1:0] s2_qr_q, s2_qg_q, s2_qb_q;
  logic [DIST_W-1:0] dist_sum;

  assign a_r = {pr_q, 8'h00};
  assign a_g = {pg_q, 8'h00};
  assign a_b = {pb_q, 8'h00};
  assign c_r = cen_r_q[ci_i];
  assign c_g = cen_g_q[ci_i];
  assign c_b = cen_b_q[ci_i];
  assign dist_sum = DIST_W'(s2_qr_q) + DIST_W'(s2_qg_q) + DIST_W'(s2_qb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      have_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.dist_issue;
      s2_v_q <= s1_v_q;
      if (cmd_i.pt_latch) begin
        have_q <= 1'b0;
      end else if (s2_v_q && s2_cv_q && (!have_q || (dist_sum < best_d_q))) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cv_q  <= cen_v_q[ci_i];
    s1_idx_q <= ci_i;
    s1_dr_q  <= (a_r > c_r) ? a_r - c_r : c_r - a_r;
    s1_dg_q  <= (a_g > c_g) ? a_g - c_g : c_g - a_g;
    s1_db_q  <= (a_b > c_b) ? a_b - c_b : c_b - a_b;
    s2_cv_q  <= s1_cv_q;
    s2_idx_q <= s1_idx_q;
    s2_qr_q  <= (2*CenW)'(s1_dr_q) * (2*CenW)'(s1_dr_q);
    s2_qg_q  <= (2*CenW)'(s1_dg_q) * (2*CenW)'(s1_dg_q);
    s2_qb_q  <= (2*CenW)'(s1_db_q) * (2*CenW)'(s1_db_q);
    if (cmd_i.pt_latch) begin
      pr_q   <= rd_r;
      pg_q   <= rd_g;
      pb_q   <= rd_b;
      pw_q   <= rd_w;
      pgrp_q <= cmd_i.use_init ? grp_i : rd_grp;
      best_q <= cmd_i.use_init ? grp_i : rd_grp;
    end else if (s2_v_q && s2_cv_q && (!have_q || (dist_sum < best_d_q))) begin
      best_q   <= s2_idx_q;
      best_d_q <= dist_sum;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cluster_index_o  <= OutIndexW'(ci_i);
      center_red_o     <= cen_r_q[ci_i];
      center_green_o   <= cen_g_q[ci_i];
      center_blue_o    <= cen_b_q[ci_i];
      member_weight_o  <= OutWeightW'(wgt_q[ci_i]);
      points_dropped_o <= cmd_i.ovf;
      last_result_o    <= cmd_i.out_last;
    end
  end

endmodule
`default_nettype wire

### design/kcc_checker.sv
// Port-level checks for the colour clustering block, bound to the top level.
`default_nettype none
module kcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_point_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  cluster_index_o,
  input logic [15:0] center_red_o,
  input logic        last_result_o
);

  // closing word starts clustering: input must stall next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_point_i |=> in_stall_o)
    else $error("input taken right after closing word");

  // no new set may load while further results of this set are due
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_result_o |-> in_stall_o)
    else $error("input open with results pending");

  // results follow back to back in cluster order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=>
      out_valid_o && (cluster_index_o == $past(cluster_index_o) + 4'd1))
    else $error("result sequence broken");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(center_red_o))
    else $error("stalled result changed");

endmodule

bind kmeans_color_clustering kcc_checker u_kcc_checker (.*);
`default_nettype wire
